// File: hdl/assert_macros.svh
// Assertion macros shared by the grid update RTL.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sgsu_pkg.sv
// Shared constants, field offsets and stage structs of the grid update block.
// Used by every module of the block; depends on nothing.
package sgsu_pkg;

    // Line buffer geometry
    localparam int MAX_WIDTH  = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int EW_W       = COL_W + 1;
    localparam int LINE_DEPTH = 2 * MAX_WIDTH;
    localparam int LINE_AW    = COL_W + 1;

    // Field widths
    localparam int ST_W   = 2;
    localparam int IMM_W  = 8;
    localparam int DRAW_W = 16;
    localparam int THR_W  = 17;
    localparam int GW_W   = 13;

    // Cell state codes
    localparam logic [ST_W-1:0] ST_SUS = 2'd0;
    localparam logic [ST_W-1:0] ST_INF = 2'd1;
    localparam logic [ST_W-1:0] ST_REC = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD = 2'd3;

    // Input tdata layout, lowest bits first
    localparam int OFF_ST    = 0;
    localparam int OFF_IMM   = OFF_ST + ST_W;
    localparam int OFF_UP    = OFF_IMM + IMM_W;
    localparam int OFF_DOWN  = OFF_UP + DRAW_W;
    localparam int OFF_LEFT  = OFF_DOWN + DRAW_W;
    localparam int OFF_RIGHT = OFF_LEFT + DRAW_W;
    localparam int OFF_REC   = OFF_RIGHT + DRAW_W;
    localparam int IN_FIELDS_W = OFF_REC + DRAW_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    // Output tdata layout, lowest bits first
    localparam int OUT_FIELDS_W = ST_W + IMM_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_INFECT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RECOVER = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_IMMUNE  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH   = 2'd3;

    localparam logic [THR_W-1:0] RST_INFECT  = 17'd32768;
    localparam logic [THR_W-1:0] RST_RECOVER = 17'd19661;
    localparam logic [IMM_W-1:0] RST_IMMUNE  = 8'd5;
    localparam logic [GW_W-1:0]  RST_WIDTH   = 13'd4000;

    typedef struct packed {
        logic [THR_W-1:0] infect_thr;
        logic [THR_W-1:0] recover_thr;
        logic [IMM_W-1:0] immune_steps;
        logic [GW_W-1:0]  grid_width;
    } t_cfg;

    // Item after raster position tracking
    typedef struct packed {
        logic              bank;
        logic [COL_W-1:0]  col;
        logic              left_ok;
        logic              right_ok;
        logic              has_up;
        logic              emit;
        logic              pad;
        logic              frame_end;
        logic [ST_W-1:0]   st;
        logic [IMM_W-1:0]  imm;
        logic [DRAW_W-1:0] d_up;
        logic [DRAW_W-1:0] d_down;
        logic [DRAW_W-1:0] d_left;
        logic [DRAW_W-1:0] d_right;
        logic [DRAW_W-1:0] d_rec;
    } t_s1;

    // Item after the line buffer read
    typedef struct packed {
        logic              left_ok;
        logic              right_ok;
        logic              has_up;
        logic              pad;
        logic              frame_end;
        logic [ST_W-1:0]   st;
        logic [DRAW_W-1:0] d_up;
        logic [DRAW_W-1:0] d_down;
        logic [DRAW_W-1:0] d_left;
        logic [DRAW_W-1:0] d_right;
        logic [DRAW_W-1:0] d_rec;
        logic [ST_W-1:0]   self_st;
        logic [ST_W-1:0]   left_st;
        logic [ST_W-1:0]   right_st;
        logic [ST_W-1:0]   up_st;
        logic [IMM_W-1:0]  self_imm;
    } t_s2;

endpackage

// File: hdl/sgsu_regs.sv
// Configuration registers behind the APB-style port.
// Depends on sgsu_pkg for register indexes, widths and reset values.
module sgsu_regs import sgsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output t_cfg              o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign wr_en = i_psel && i_penable && i_pwrite;
    assign idx   = i_paddr[APB_AW-1:2];

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.infect_thr   <= RST_INFECT;
            r_cfg.recover_thr  <= RST_RECOVER;
            r_cfg.immune_steps <= RST_IMMUNE;
            r_cfg.grid_width   <= RST_WIDTH;
        end else if (wr_en) begin
            case (idx)
                REG_INFECT:  r_cfg.infect_thr   <= i_pwdata[THR_W-1:0];
                REG_RECOVER: r_cfg.recover_thr  <= i_pwdata[THR_W-1:0];
                REG_IMMUNE:  r_cfg.immune_steps <= i_pwdata[IMM_W-1:0];
                REG_WIDTH:   r_cfg.grid_width   <= i_pwdata[GW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (idx)
            REG_INFECT:  o_prdata = APB_DW'(r_cfg.infect_thr);
            REG_RECOVER: o_prdata = APB_DW'(r_cfg.recover_thr);
            REG_IMMUNE:  o_prdata = APB_DW'(r_cfg.immune_steps);
            REG_WIDTH:   o_prdata = APB_DW'(r_cfg.grid_width);
            default:     o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/sgsu_front.sv
// First stage: tracks column, row phase and buffer bank of the raster stream.
// Depends on sgsu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sgsu_front import sgsu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_valid,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic                 i_pad,
    output logic                 o_ready,
    input  logic                 i_next_ready,
    output logic                 o_valid,
    output t_s1                  o_item
);

    typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_LATER} t_phase;

    t_phase           r_phase, n_phase;
    logic             r_bank, n_bank;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_valid;
    t_s1              r_item, n_item;

    logic [EW_W-1:0]  w;
    logic [COL_W-1:0] cc;
    logic             last;
    logic             accept;
    logic             drop;
    logic             store;
    logic [ST_W-1:0]  in_st;

    assign o_ready = i_rst_n && (!r_valid || i_next_ready);
    assign accept  = i_valid && o_ready;
    assign drop    = (r_phase == PH_FIRST) && i_pad;
    assign store   = accept && !drop;

    // Clamp the width and the column
    always_comb begin
        if (32'(i_cfg.grid_width) > MAX_WIDTH) begin
            w = EW_W'(MAX_WIDTH);
        end else if (i_cfg.grid_width < GW_W'(2)) begin
            w = EW_W'(2);
        end else begin
            w = EW_W'(i_cfg.grid_width);
        end
        if (EW_W'(r_col) >= w) begin
            cc = COL_W'(w - EW_W'(1));
        end else begin
            cc = r_col;
        end
        last  = (EW_W'(cc) + EW_W'(1)) >= w;
        in_st = i_data[OFF_ST +: ST_W];
    end

    // Build the item for the line buffer stage
    always_comb begin
        n_item.bank      = r_bank;
        n_item.col       = cc;
        n_item.left_ok   = (cc != '0);
        n_item.right_ok  = !last;
        n_item.has_up    = (r_phase == PH_LATER);
        n_item.emit      = (r_phase != PH_FIRST);
        n_item.pad       = i_pad;
        n_item.frame_end = i_pad && last;
        n_item.st        = (i_pad || in_st == ST_BAD) ? ST_SUS : in_st;
        n_item.imm       = i_pad ? '0 : i_data[OFF_IMM +: IMM_W];
        n_item.d_up      = i_data[OFF_UP +: DRAW_W];
        n_item.d_down    = i_data[OFF_DOWN +: DRAW_W];
        n_item.d_left    = i_data[OFF_LEFT +: DRAW_W];
        n_item.d_right   = i_data[OFF_RIGHT +: DRAW_W];
        n_item.d_rec     = i_data[OFF_REC +: DRAW_W];
    end

    // Advance the raster position
    always_comb begin
        n_phase = r_phase;
        n_bank  = r_bank;
        n_col   = r_col;
        if (store) begin
            if (last) begin
                n_col  = '0;
                n_bank = ~r_bank;
                if (i_pad) begin
                    n_phase = PH_FIRST;
                end else begin
                    case (r_phase)
                        PH_FIRST:  n_phase = PH_SECOND;
                        PH_SECOND: n_phase = PH_LATER;
                        default:   n_phase = PH_LATER;
                    endcase
                end
            end else begin
                n_col = cc + COL_W'(1);
            end
        end
    end

    // Hold position state and the stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_bank  <= 1'b0;
            r_col   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bank  <= n_bank;
            r_col   <= n_col;
            if (o_ready) begin
                r_valid <= store;
            end
            if (store) begin
                r_item <= n_item;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    `ASSERT_NEXT(a_col_wraps, i_clk, i_rst_n, i_rst_n && store && last, r_col == '0,
        "column did not return to zero after the last column")
    `ASSERT_NEXT(a_bank_flips, i_clk, i_rst_n, i_rst_n && store && last,
        r_bank != $past(r_bank), "buffer bank did not swap at row end")

endmodule

// File: hdl/sgsu_lines.sv
// Second stage: state and immune line buffers, written and read per item.
// Depends on sgsu_pkg. State lines exist twice so each copy has two read ports.
module sgsu_lines import sgsu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_s1  i_item,
    output logic o_ready,
    input  logic i_next_ready,
    output logic o_valid,
    output t_s2  o_item
);

    logic [ST_W-1:0]  r_line_a [0:LINE_DEPTH-1];
    logic [ST_W-1:0]  r_line_b [0:LINE_DEPTH-1];
    logic [IMM_W-1:0] r_imm_line [0:MAX_WIDTH-1];

    logic             r_valid;
    t_s2              r_item;

    logic             move;
    logic [LINE_AW-1:0] a_cur, a_oth, a_left, a_right;

    assign o_ready = !r_valid || i_next_ready;
    assign move    = i_valid && o_ready;

    // Addresses in the current bank (row above input) and the other bank
    assign a_cur   = {i_item.bank, i_item.col};
    assign a_oth   = {~i_item.bank, i_item.col};
    assign a_left  = {i_item.bank, i_item.col - COL_W'(1)};
    assign a_right = {i_item.bank, i_item.col + COL_W'(1)};

    // Read old contents and store the incoming cell on the same edge
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_line_a[a_oth]          <= i_item.st;
            r_line_b[a_oth]          <= i_item.st;
            r_imm_line[i_item.col]   <= i_item.imm;
            r_item.left_st           <= r_line_a[a_left];
            r_item.self_st           <= r_line_a[a_cur];
            r_item.right_st          <= r_line_b[a_right];
            r_item.up_st             <= r_line_b[a_oth];
            r_item.self_imm          <= r_imm_line[i_item.col];
            r_item.left_ok           <= i_item.left_ok;
            r_item.right_ok          <= i_item.right_ok;
            r_item.has_up            <= i_item.has_up;
            r_item.pad               <= i_item.pad;
            r_item.frame_end         <= i_item.frame_end;
            r_item.st                <= i_item.st;
            r_item.d_up              <= i_item.d_up;
            r_item.d_down            <= i_item.d_down;
            r_item.d_left            <= i_item.d_left;
            r_item.d_right           <= i_item.d_right;
            r_item.d_rec             <= i_item.d_rec;
        end
    end

    // Pass on only items that produce a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && i_item.emit;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hdl/sgsu_rule.sv
// Third stage: applies the update rule and holds the result register.
// Depends on sgsu_pkg.
module sgsu_rule import sgsu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    input  t_s2              i_item,
    output logic             o_ready,
    input  logic             i_out_ready,
    output logic             o_valid,
    output logic [ST_W-1:0]  o_state,
    output logic [IMM_W-1:0] o_immune,
    output logic             o_frame_end
);

    logic             r_valid;
    logic [ST_W-1:0]  r_state, n_state;
    logic [IMM_W-1:0] r_immune, n_immune;
    logic             r_frame_end;

    logic             up_inf, down_inf, left_inf, right_inf, recover;

    assign o_ready = !r_valid || i_out_ready;

    // Infection and recovery tests
    always_comb begin
        up_inf    = i_item.has_up && (i_item.up_st == ST_INF)
                    && (THR_W'(i_item.d_up) < i_cfg.infect_thr);
        down_inf  = !i_item.pad && (i_item.st == ST_INF)
                    && (THR_W'(i_item.d_down) < i_cfg.infect_thr);
        left_inf  = i_item.left_ok && (i_item.left_st == ST_INF)
                    && (THR_W'(i_item.d_left) < i_cfg.infect_thr);
        right_inf = i_item.right_ok && (i_item.right_st == ST_INF)
                    && (THR_W'(i_item.d_right) < i_cfg.infect_thr);
        recover   = THR_W'(i_item.d_rec) < i_cfg.recover_thr;
    end

    // Next state of the output cell
    always_comb begin
        n_state  = i_item.self_st;
        n_immune = i_item.self_imm;
        case (i_item.self_st)
            ST_SUS: begin
                if (up_inf || down_inf || left_inf || right_inf) begin
                    n_state = ST_INF;
                end
            end
            ST_INF: begin
                if (recover) begin
                    n_state  = ST_REC;
                    n_immune = i_cfg.immune_steps;
                end
            end
            default: begin
                if (i_item.self_imm <= IMM_W'(1)) begin
                    n_state  = ST_SUS;
                    n_immune = '0;
                end else begin
                    n_immune = i_item.self_imm - IMM_W'(1);
                end
            end
        endcase
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (o_ready && i_valid) begin
                r_state     <= n_state;
                r_immune    <= n_immune;
                r_frame_end <= i_item.frame_end;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_state     = r_state;
    assign o_immune    = r_immune;
    assign o_frame_end = r_frame_end;

endmodule

// File: hdl/sir_grid_stencil_update.sv
// One generation of a stochastic susceptible-infected-recovered grid.
// Cells enter on the s_axis channel in raster order, grid_width per row,
// followed by one padding row (s_axis_tuser high). Each accepted item yields
// the updated cell of the row above it, at the same column, on m_axis; items
// of the first grid row are stored only. m_axis_tlast marks the last cell of
// the generation. Thresholds, immune steps and width are set over the APB
// port; the user must do so only while the block is idle (not enforced).
// Pipeline: an accepted item passes through the position stage, the line
// buffer stage and the rule stage registers before its result is on m_axis.
// Throughput: one item per cycle while m_axis_tready is high; line buffers are
// read and written once per item in the same cycle; items never wait on each other.
// Reset: returns to the first grid row at column zero and restores the
// register defaults; the line buffers keep their contents and are refilled
// by the first row of the next frame.
// Stall: while m_axis_tready is low the three stage registers fill up, and
// s_axis_tready falls, outside reset, only when all three hold an item.
// Depends on sgsu_pkg, sgsu_regs, sgsu_front, sgsu_lines, sgsu_rule.
`include "assert_macros.svh"
module sir_grid_stencil_update import sgsu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tdata: cell_state[1:0], immune_left[9:2], draw_from_up[25:10],
    // draw_from_down[41:26], draw_from_left[57:42], draw_from_right[73:58],
    // draw_recover[89:74], zero fill above
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: is_padding[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: next_state[1:0], next_immune[9:2], zero fill above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tlast: frame_end
    output logic                  m_axis_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    t_cfg             cfg;
    logic             v1, v2;
    t_s1              s1;
    t_s2              s2;
    logic             rdy2, rdy3;
    logic [ST_W-1:0]  out_state;
    logic [IMM_W-1:0] out_immune;

    assign pready = 1'b1;

    sgsu_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    sgsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (s_axis_tvalid),
        .i_data       (s_axis_tdata),
        .i_pad        (s_axis_tuser),
        .o_ready      (s_axis_tready),
        .i_next_ready (rdy2),
        .o_valid      (v1),
        .o_item       (s1)
    );

    sgsu_lines u_lines (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (v1),
        .i_item       (s1),
        .o_ready      (rdy2),
        .i_next_ready (rdy3),
        .o_valid      (v2),
        .o_item       (s2)
    );

    sgsu_rule u_rule (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (v2),
        .i_item      (s2),
        .o_ready     (rdy3),
        .i_out_ready (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_state     (out_state),
        .o_immune    (out_immune),
        .o_frame_end (m_axis_tlast)
    );

    // Pack the result fields
    assign m_axis_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, out_immune, out_state};

    `ASSERT_HOLDS(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready, "input stalled while the output was free")

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for sir_grid_stencil_update: streams raster generations of SIR cells
// and checks each result against a line-buffer predictor or the directed table.
// Depends on sgsu_pkg and the sir_grid_stencil_update RTL only.
module tb;
    import sgsu_pkg::*;

    localparam logic [DRAW_W-1:0] DMAX = 16'hFFFF;

    typedef struct packed {
        logic [ST_W-1:0]   st;
        logic [IMM_W-1:0]  imm;
        logic [DRAW_W-1:0] d_up, d_down, d_left, d_right, d_rec;
        logic              pad;
    } t_cell;

    typedef struct packed {
        logic [ST_W-1:0]  st;
        logic [IMM_W-1:0] imm;
        logic             fe;
    } t_gen_res;

    typedef struct packed {
        t_cell    c;
        logic     chk;
        t_gen_res r;
    } t_dir_row;

    // Width 3, every draw passes, recovery always, immune steps zero
    localparam t_dir_row DIR_CELLS [0:12] = '{
        // padding inside the first row is dropped
        '{'{ST_SUS, 8'd255, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b1}, 1'b0, '{ST_SUS, 8'd0, 1'b0}},
        // first row: stored only
        '{'{ST_INF, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '{ST_SUS, 8'd0, 1'b0}},
        '{'{ST_SUS, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '{ST_SUS, 8'd0, 1'b0}},
        '{'{ST_REC, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '{ST_SUS, 8'd0, 1'b0}},
        // second row: state code three enters as susceptible
        '{'{ST_BAD, 8'd255, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b0}, 1'b1, '{ST_REC, 8'd0, 1'b0}},
        '{'{ST_SUS, 8'd0, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b0}, 1'b1, '{ST_INF, 8'd0, 1'b0}},
        '{'{ST_SUS, 8'd0, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b0}, 1'b1, '{ST_SUS, 8'd0, 1'b0}},
        // third row: absent cell in the middle column
        '{'{ST_INF, 8'd9, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b0}, 1'b1, '{ST_INF, 8'd255, 1'b0}},
        '{'{ST_SUS, 8'd0, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b1}, 1'b1, '{ST_SUS, 8'd0, 1'b0}},
        '{'{ST_REC, 8'd200, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b0}, 1'b1, '{ST_SUS, 8'd0, 1'b0}},
        // padding row closes the generation
        '{'{ST_SUS, 8'd0, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b1}, 1'b1, '{ST_REC, 8'd0, 1'b0}},
        '{'{ST_SUS, 8'd0, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b1}, 1'b1, '{ST_INF, 8'd0, 1'b0}},
        '{'{ST_SUS, 8'd0, DMAX, DMAX, DMAX, DMAX, DMAX, 1'b1}, 1'b1, '{ST_REC, 8'd199, 1'b1}}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: cell_state, immune_left, draw_from_up, draw_from_down, draw_from_left,
    // draw_from_right, draw_recover, zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // tuser: is_padding
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: next_state, next_immune, zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // Predictor copy of the line buffers, raster position and registers
    bit [ST_W-1:0]  line_st [2*MAX_WIDTH];
    bit [IMM_W-1:0] line_imm [MAX_WIDTH];
    int             col_pos = 0;
    int             row_phase = 0;
    bit             bank = 1'b0;
    logic [THR_W-1:0] cfg_infect = RST_INFECT;
    logic [THR_W-1:0] cfg_recover = RST_RECOVER;
    logic [IMM_W-1:0] cfg_immune = RST_IMMUNE;
    logic [GW_W-1:0]  cfg_width = RST_WIDTH;

    t_gen_res next_gen_q [$];
    int       errors = 0;
    int       cells_sent = 0;
    int       hold_request = 0;
    bit       quiet = 1'b0;
    bit       calm = 1'b0;

    sir_grid_stencil_update u_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int clamp_width(input logic [GW_W-1:0] gw);
        if (gw > MAX_WIDTH) return MAX_WIDTH;
        if (gw < 2) return 2;
        return int'(gw);
    endfunction

    // Advance the grid by one cell; return 1 when the cell one row up is updated
    function automatic bit sir_update(input t_cell c, output t_gen_res r);
        int w, cc, cur, oth;
        logic [ST_W-1:0]  st, self_st;
        logic [IMM_W-1:0] imm, self_imm;
        bit last, hit, made;
        w = clamp_width(cfg_width);
        cc = (col_pos >= w) ? w - 1 : col_pos;
        st = (c.st == ST_BAD || c.pad) ? ST_SUS : c.st;
        imm = c.pad ? '0 : c.imm;
        last = (cc + 1 >= w);
        cur = bank ? MAX_WIDTH : 0;
        oth = bank ? 0 : MAX_WIDTH;
        r = '0;
        made = 1'b0;
        if (row_phase == 0 && c.pad) return 1'b0;
        if (row_phase != 0) begin
            self_st = line_st[cur + cc];
            self_imm = line_imm[cc];
            r.st = self_st;
            r.imm = self_imm;
            if (self_st == ST_SUS) begin
                hit = (row_phase >= 2 && line_st[oth + cc] == ST_INF && c.d_up < cfg_infect)
                   || (!c.pad && st == ST_INF && c.d_down < cfg_infect)
                   || (cc > 0 && line_st[cur + cc - 1] == ST_INF && c.d_left < cfg_infect)
                   || (cc + 1 < w && line_st[cur + cc + 1] == ST_INF
                       && c.d_right < cfg_infect);
                if (hit) r.st = ST_INF;
            end else if (self_st == ST_INF) begin
                if (c.d_rec < cfg_recover) begin
                    r.st = ST_REC;
                    r.imm = cfg_immune;
                end
            end else if (self_imm <= 1) begin
                r.st = ST_SUS;
                r.imm = '0;
            end else begin
                r.imm = self_imm - IMM_W'(1);
            end
            r.fe = c.pad && last;
            made = 1'b1;
        end
        // store the incoming cell and step the raster position
        line_st[oth + cc] = st;
        line_imm[cc] = imm;
        if (last) begin
            col_pos = 0;
            bank = ~bank;
            if (c.pad) row_phase = 0;
            else if (row_phase < 2) row_phase++;
        end else begin
            col_pos = cc + 1;
        end
        return made;
    endfunction

    // Mostly uniform, sometimes right at the threshold
    function automatic logic [DRAW_W-1:0] rand_draw(input logic [THR_W-1:0] thr);
        int v;
        if ($urandom_range(0, 3) != 0) return DRAW_W'($urandom_range(0, 65535));
        v = int'(thr) - 1 + int'($urandom_range(0, 2));
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return DRAW_W'(v);
    endfunction

    function automatic t_cell rand_cell(input logic pad);
        t_cell c;
        case ($urandom_range(0, 9))
            0:       c.st = ST_BAD;
            1, 2, 3: c.st = ST_INF;
            4, 5:    c.st = ST_REC;
            default: c.st = ST_SUS;
        endcase
        c.imm = $urandom_range(0, 1) ? IMM_W'($urandom_range(0, 3))
                                     : IMM_W'($urandom_range(0, 255));
        c.d_up = rand_draw(cfg_infect);
        c.d_down = rand_draw(cfg_infect);
        c.d_left = rand_draw(cfg_infect);
        c.d_right = rand_draw(cfg_infect);
        c.d_rec = rand_draw(cfg_recover);
        c.pad = pad;
        return c;
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 17'd65536;
            2:       return THR_W'($urandom_range(65537, 131071));
            default: return THR_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one item, wait for it to be taken, then predict its result
    task automatic drive_cell(input t_cell c, input logic chk, input t_gen_res typed);
        t_gen_res r;
        logic [IN_DATA_W-1:0] word;
        @(negedge i_clk);
        if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        word = '0;
        word[IN_FIELDS_W-1:0] = {c.d_rec, c.d_right, c.d_left, c.d_down, c.d_up, c.imm, c.st};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= c.pad;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!(row_phase == 0 && c.pad)) cells_sent++;
        if (sir_update(c, r)) begin
            if (chk) r = typed;
            next_gen_q = {next_gen_q, r};
        end
    endtask

    // Send n random items, flipping the padding flag now and then when noisy
    task automatic send_row(input logic pad, input int n, input bit noisy);
        t_cell c;
        for (int i = 0; i < n; i++) begin
            c = rand_cell(pad);
            if (noisy && $urandom_range(0, 24) == 0) c.pad = ~c.pad;
            drive_cell(c, 1'b0, '0);
        end
    endtask

    // Pad until the generation closes, completing an open first row with cells first
    task automatic flush_frame();
        while (row_phase != 0 || col_pos != 0)
            drive_cell(rand_cell(row_phase != 0), 1'b0, '0);
    endtask

    // Drop valid, drain all results, then cover the pipeline latency
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (next_gen_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_read_check(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] exp);
        logic [APB_DW-1:0] rd;
        apb_xfer(1'b0, idx, '0, rd);
        if (rd !== exp) begin
            $error("register %0d readback: expected %0h, actual %0h", idx, exp, rd);
            errors++;
        end
    endtask

    // Write a register, mirror it in the predictor, read it back
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] rd, exp;
        apb_xfer(1'b1, idx, val, rd);
        case (idx)
            REG_INFECT: begin
                cfg_infect = val[THR_W-1:0];
                exp = APB_DW'(cfg_infect);
            end
            REG_RECOVER: begin
                cfg_recover = val[THR_W-1:0];
                exp = APB_DW'(cfg_recover);
            end
            REG_IMMUNE: begin
                cfg_immune = val[IMM_W-1:0];
                exp = APB_DW'(cfg_immune);
            end
            default: begin
                cfg_width = val[GW_W-1:0];
                exp = APB_DW'(cfg_width);
            end
        endcase
        reg_read_check(idx, exp);
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_gen_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (next_gen_q.size() == 0) begin
                $error("unexpected item: next_state %0d next_immune %0d frame_end %0d",
                       m_axis_tdata[ST_W-1:0], m_axis_tdata[ST_W+IMM_W-1:ST_W], m_axis_tlast);
                errors++;
            end else begin
                want = next_gen_q.pop_front();
                if (m_axis_tdata[ST_W-1:0] !== want.st) begin
                    $error("next_state: expected %0d, actual %0d",
                           want.st, m_axis_tdata[ST_W-1:0]);
                    errors++;
                end
                if (m_axis_tdata[ST_W+IMM_W-1:ST_W] !== want.imm) begin
                    $error("next_immune: expected %0d, actual %0d",
                           want.imm, m_axis_tdata[ST_W+IMM_W-1:ST_W]);
                    errors++;
                end
                if (m_axis_tlast !== want.fe) begin
                    $error("frame_end: expected %0d, actual %0d", want.fe, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Result side: random stall bursts plus a long hold-off on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (!quiet && !calm && $urandom_range(0, 11) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 18);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int phase, rows, w_eff;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Register defaults after reset
        reg_read_check(REG_INFECT, APB_DW'(RST_INFECT));
        reg_read_check(REG_RECOVER, APB_DW'(RST_RECOVER));
        reg_read_check(REG_IMMUNE, APB_DW'(RST_IMMUNE));
        reg_read_check(REG_WIDTH, APB_DW'(RST_WIDTH));

        // Directed generation on a three-wide grid
        reg_write(REG_INFECT, 32'd65536);
        reg_write(REG_RECOVER, 32'd65536);
        reg_write(REG_IMMUNE, 32'd0);
        reg_write(REG_WIDTH, 32'd3);
        foreach (DIR_CELLS[i]) drive_cell(DIR_CELLS[i].c, DIR_CELLS[i].chk, DIR_CELLS[i].r);
        settle();

        // Shrink the width mid-row so the column lands past the new last column
        reg_write(REG_INFECT, 32'd40000);
        reg_write(REG_RECOVER, 32'd30000);
        reg_write(REG_IMMUNE, 32'd3);
        reg_write(REG_WIDTH, 32'd10);
        send_row(1'b0, 10, 1'b0);
        send_row(1'b0, 7, 1'b0);
        settle();
        reg_write(REG_WIDTH, 32'd4);
        send_row(1'b0, 1, 1'b0);
        send_row(1'b0, 4, 1'b0);
        send_row(1'b1, 4, 1'b0);
        settle();

        // Random generations, new settings at each idle boundary
        for (phase = 0; cells_sent < 800; phase++) begin
            case (phase)
                0: begin
                    reg_write(REG_INFECT, 32'd0);
                    reg_write(REG_RECOVER, 32'd0);
                    reg_write(REG_IMMUNE, 32'd255);
                    reg_write(REG_WIDTH, 32'd0);
                end
                1: begin
                    reg_write(REG_INFECT, 32'd131071);
                    reg_write(REG_RECOVER, 32'd65536);
                    reg_write(REG_IMMUNE, 32'd1);
                    reg_write(REG_WIDTH, 32'd1);
                end
                2: begin
                    reg_write(REG_INFECT, 32'd65536);
                    reg_write(REG_RECOVER, 32'd0);
                    reg_write(REG_IMMUNE, 32'd0);
                    reg_write(REG_WIDTH, 32'd2);
                end
                default: begin
                    reg_write(REG_INFECT, APB_DW'(pick_threshold()));
                    reg_write(REG_RECOVER, APB_DW'(pick_threshold()));
                    reg_write(REG_IMMUNE, $urandom_range(0, 255));
                    case ($urandom_range(0, 9))
                        0:       reg_write(REG_WIDTH, $urandom_range(13, 64));
                        1:       reg_write(REG_WIDTH, $urandom_range(0, 1));
                        default: reg_write(REG_WIDTH, $urandom_range(2, 12));
                    endcase
                end
            endcase
            calm = ($urandom_range(0, 3) == 0);
            // hold the result side off long enough to back up the input
            if (phase == 3) hold_request = 120;
            w_eff = clamp_width(cfg_width);
            repeat ($urandom_range(1, 3)) begin
                rows = $urandom_range(1, 5);
                repeat (rows) send_row(1'b0, w_eff, 1'b1);
                send_row(1'b1, w_eff, 1'b1);
                flush_frame();
            end
            quiet = (cells_sent > 650);
            settle();
        end

        if (errors == 0 && next_gen_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/sgsu_pkg.sv
hdl/sgsu_regs.sv
hdl/sgsu_front.sv
hdl/sgsu_lines.sv
hdl/sgsu_rule.sv
hdl/sir_grid_stencil_update.sv
sim/tb.sv
